// ===== rtl/core/elt_pkg.sv =====
package elt_pkg;

  localparam int MAX_TOKENS = 64;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [3:0] {
    CL_ZERO,
    CL_SPACE,
    CL_OPEN,
    CL_CLOSE,
    CL_QUOTE,
    CL_PLUS,
    CL_MINUS,
    CL_ALPHA,
    CL_BODY,
    CL_OTHER
  } class_t;

  typedef enum logic [2:0] {
    PH_LINE,
    PH_PRE,
    PH_START,
    PH_QUOTE,
    PH_QEND,
    PH_BODY,
    PH_CLOSE,
    PH_AFTOP
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_TOKEN,
    KIND_LINE,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    logic [7:0] ch;
    class_t     cls;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        char_out;
    logic [7:0]        op_code;
    logic signed [7:0] level;
    logic [6:0]        token_index;
    logic              last;
  } res_t;

endpackage

// ===== rtl/core/elt_if.sv =====
interface elt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface elt_tok_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        char_out;
  logic [7:0]        op_code;
  logic signed [7:0] level;
  logic [6:0]        token_index;
  logic              last;

  modport source (output valid, output kind, output char_out, output op_code,
                  output level, output token_index, output last, input ready);
  modport sink (input valid, input kind, input char_out, input op_code,
                input level, input token_index, input last, output ready);
endinterface

// ===== rtl/core/expression_line_tokenizer.sv =====
// Expression line tokenizer.
// char_stream: one character per transaction (valid/ready), code 0 ends the line.
// token_stream: result transactions - parameter characters, token ends with
//   operator and bracket level, line ends with the running token index, or
//   an error if the line ends in or just after a quoted parameter. last marks
//   the last result of a character; a character gives zero, one or two results.
// cfg_we/cfg_wdata: writes the start index of the next line's tokens; it
//   clears itself when that line begins. Write only while idle.
// Path: front-end holding register, queue, output register. Throughput: one
//   character per cycle while the receiver is ready; the output register issues
//   one result per cycle, so a character with two results holds the back end
//   until its second result is issued, absorbed by the four-entry queue.
// Reset: scanner at line start, depth, count and start index cleared, queue
//   and output empty.
// Receiver stall: the output holds its result; the queue fills, then
//   char_stream.ready drops. No result is lost or repeated.
module expression_line_tokenizer
  import elt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  elt_char_if.sink   char_stream,
  elt_tok_if.source  token_stream,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata
);

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  elt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_stream(char_stream),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  elt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  elt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .token_stream(token_stream)
  );

endmodule

// ===== rtl/core/elt_front.sv =====
module elt_front
  import elt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  elt_char_if.sink  char_stream,
  output logic      push_valid,
  input  logic      push_ready,
  output item_t     push_item
);

  function automatic class_t classify(input logic [7:0] c);
    class_t r;
    if (c == 8'd0) r = CL_ZERO;
    else if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) r = CL_SPACE;
    else if (c == "(" || c == "[") r = CL_OPEN;
    else if (c == ")" || c == "]") r = CL_CLOSE;
    else if (c == "\"") r = CL_QUOTE;
    else if (c == "+") r = CL_PLUS;
    else if (c == "-") r = CL_MINUS;
    else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) r = CL_ALPHA;
    else if ((c >= "0" && c <= "9") || c == "." || c == "_") r = CL_BODY;
    else r = CL_OTHER;
    return r;
  endfunction

  logic  held;
  item_t item;
  logic  take;

  assign char_stream.ready = !held || push_ready;
  assign take       = char_stream.valid && char_stream.ready;
  assign push_valid = held;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.ch  <= char_stream.char_in;
      item.cls <= classify(char_stream.char_in);
    end
  end

endmodule

// ===== rtl/core/elt_fifo.sv =====
module elt_fifo
  import elt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count != FIFO_CW'(FIFO_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/core/elt_back.sv =====
module elt_back
  import elt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  item_t      pop_item,
  elt_tok_if.source  token_stream
);

  phase_t            phase, phase_next;
  logic signed [7:0] depth, depth_next;
  logic signed [7:0] dbc, dbc_next;
  logic [6:0]        counter, counter_next;
  logic [5:0]        first_idx, first_idx_next;

  res_t       r0, r1;
  logic [1:0] n;
  logic       go;
  logic [7:0] c;
  class_t     cl;

  res_t out_res, pend_res;
  logic out_valid, pend_valid;
  logic pop;
  logic out_free;

  function automatic logic signed [7:0] up(input logic signed [7:0] d);
    return (d != 8'sd127) ? d + 8'sd1 : d;
  endfunction

  function automatic logic signed [7:0] down(input logic signed [7:0] d);
    return (d != -8'sd128) ? d - 8'sd1 : d;
  endfunction

  function automatic res_t mk(input kind_t k, input logic [7:0] ch, input logic [7:0] op,
                              input logic signed [7:0] lvl, input logic [6:0] idx);
    res_t r;
    r.kind        = k;
    r.char_out    = ch;
    r.op_code     = op;
    r.level       = lvl;
    r.token_index = idx;
    r.last        = 1'b0;
    return r;
  endfunction

  always_comb begin
    phase_next     = phase;
    depth_next     = depth;
    dbc_next       = dbc;
    counter_next   = counter;
    first_idx_next = first_idx;
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    go = 1'b1;
    c  = pop_item.ch;
    cl = pop_item.cls;

    // line start and after-operator entry
    if (phase_next == PH_LINE) begin
      if (cl == CL_ZERO) begin
        r0 = mk(KIND_LINE, 8'd0, 8'd0, -8'sd1, {1'b0, first_idx_next});
        n  = 2'd1;
        first_idx_next = '0;
        go = 1'b0;
      end else begin
        counter_next   = {1'b0, first_idx_next};
        first_idx_next = '0;
        depth_next     = '0;
        phase_next     = PH_PRE;
      end
    end else if (phase_next == PH_AFTOP) begin
      if (cl == CL_ZERO) begin
        r0 = mk(KIND_LINE, 8'd0, 8'd0, -8'sd1, counter_next);
        n  = 2'd1;
        phase_next = PH_LINE;
        go = 1'b0;
      end else begin
        phase_next = PH_PRE;
      end
    end

    // leading spaces, open brackets, one plus
    if (go && phase_next == PH_PRE) begin
      if (cl == CL_SPACE) begin
        go = 1'b0;
      end else if (cl == CL_OPEN) begin
        depth_next = up(depth_next);
        go = 1'b0;
      end else begin
        phase_next = PH_START;
        if (cl == CL_PLUS) go = 1'b0;
      end
    end

    // parameter body
    if (go) begin
      unique case (phase_next)
        PH_START: begin
          if (cl == CL_QUOTE) begin
            r0 = mk(KIND_CHAR, c, 8'd0, 8'sd0, 7'd0);
            n  = 2'd1;
            phase_next = PH_QUOTE;
            go = 1'b0;
          end else if (cl == CL_MINUS || cl == CL_ALPHA || cl == CL_BODY) begin
            r0 = mk(KIND_CHAR, c, 8'd0, 8'sd0, 7'd0);
            n  = 2'd1;
            phase_next = PH_BODY;
            go = 1'b0;
          end else begin
            dbc_next   = depth_next;
            phase_next = PH_CLOSE;
          end
        end
        PH_QUOTE: begin
          if (cl == CL_ZERO) begin
            r0 = mk(KIND_ERROR, 8'd0, 8'd0, 8'sd0, 7'd0);
            phase_next = PH_LINE;
          end else begin
            r0 = mk(KIND_CHAR, c, 8'd0, 8'sd0, 7'd0);
            if (cl == CL_QUOTE) phase_next = PH_QEND;
          end
          n  = 2'd1;
          go = 1'b0;
        end
        PH_QEND: begin
          if (cl == CL_ZERO) begin
            r0 = mk(KIND_ERROR, 8'd0, 8'd0, 8'sd0, 7'd0);
            n  = 2'd1;
            phase_next = PH_LINE;
            go = 1'b0;
          end else begin
            dbc_next   = depth_next;
            phase_next = PH_CLOSE;
          end
        end
        PH_BODY: begin
          if (cl == CL_ALPHA || cl == CL_BODY) begin
            r0 = mk(KIND_CHAR, c, 8'd0, 8'sd0, 7'd0);
            n  = 2'd1;
            go = 1'b0;
          end else begin
            dbc_next   = depth_next;
            phase_next = PH_CLOSE;
          end
        end
        default: ;
      endcase
    end

    // closing brackets and token end
    if (go && phase_next == PH_CLOSE) begin
      go = 1'b0;
      if (cl == CL_CLOSE) begin
        depth_next = down(depth_next);
      end else if (cl != CL_SPACE) begin
        if (cl == CL_OPEN) depth_next = up(depth_next);
        if (counter_next < 7'(MAX_TOKENS)) counter_next = counter_next + 7'd1;
        if (cl == CL_ALPHA) begin
          r0 = mk(KIND_TOKEN, 8'd0, 8'd0,
                  (dbc_next < depth_next) ? dbc_next : depth_next, counter_next);
          r1 = mk(KIND_CHAR, c, 8'd0, 8'sd0, 7'd0);
          n  = 2'd2;
          phase_next = PH_BODY;
        end else if (cl == CL_ZERO) begin
          r0 = mk(KIND_TOKEN, 8'd0, 8'd0,
                  (dbc_next < depth_next) ? dbc_next : depth_next, counter_next);
          r1 = mk(KIND_LINE, 8'd0, 8'd0, -8'sd1, counter_next);
          n  = 2'd2;
          phase_next = PH_LINE;
        end else begin
          r0 = mk(KIND_TOKEN, 8'd0, c,
                  (dbc_next < depth_next) ? dbc_next : depth_next, counter_next);
          n  = 2'd1;
          phase_next = PH_AFTOP;
        end
      end
    end

    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  assign out_free  = !out_valid || token_stream.ready;
  assign pop_ready = !pend_valid && (n == 2'd0 || out_free);
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LINE;
      depth      <= '0;
      dbc        <= '0;
      counter    <= '0;
      first_idx  <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase   <= phase_next;
        depth   <= depth_next;
        dbc     <= dbc_next;
        counter <= counter_next;
      end
      if (cfg_we) begin
        first_idx <= cfg_wdata;
      end else if (pop) begin
        first_idx <= first_idx_next;
      end
      if (pend_valid && out_free) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (pop && n != 2'd0) begin
        out_valid  <= 1'b1;
        pend_valid <= (n == 2'd2);
      end else if (token_stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid && out_free) begin
      out_res <= pend_res;
    end else if (pop && n != 2'd0) begin
      out_res  <= r0;
      pend_res <= r1;
    end
  end

  assign token_stream.valid       = out_valid;
  assign token_stream.kind        = out_res.kind;
  assign token_stream.char_out    = out_res.char_out;
  assign token_stream.op_code     = out_res.op_code;
  assign token_stream.level       = out_res.level;
  assign token_stream.token_index = out_res.token_index;
  assign token_stream.last        = out_res.last;

endmodule
